// ===== src/cmdt_pkg.sv =====
// ----------------------------------------------------------------------------
// cube map texel addressing package
// shared widths, constants and the cordic angle table function
// ----------------------------------------------------------------------------
package cmdt_pkg;

   localparam int ANG_W        = 26;
   localparam int VEC_W        = 20;   // q2.16 plus headroom
   localparam int CORDIC_STEPS = 16;
   localparam int FACE_W       = 3;
   localparam int IDX_W        = 11;
   localparam int SIZE_W       = 13;   // holds sizes up to 4096
   localparam int DIV_W        = 34;   // numerator width

   localparam int FACE_WIDTH_DEF  = 2048;
   localparam int FACE_HEIGHT_DEF = 2048;

   localparam logic signed [ANG_W-1:0] TURN_Q16         = 26'sd23592960;
   localparam logic signed [ANG_W+1:0] HALF_TURN_Q16    = 28'sd11796480;
   localparam logic signed [ANG_W+1:0] QUARTER_TURN_Q16 = 28'sd5898240;
   localparam logic signed [VEC_W-1:0] CORDIC_GAIN_Q16  = 20'sd39797;

   typedef enum logic [FACE_W-1:0] {
      FACE_POS_Z = 3'd0,
      FACE_NEG_Z = 3'd1,
      FACE_NEG_X = 3'd2,
      FACE_POS_X = 3'd3,
      FACE_NEG_Y = 3'd4,
      FACE_POS_Y = 3'd5
   } face_type;

   // rotation state handed from cell to cell
   typedef struct packed {
      logic signed [VEC_W-1:0] x;
      logic signed [VEC_W-1:0] y;
      logic signed [ANG_W+1:0] z;
      logic                    flip;
   } rot_type;

   function automatic logic signed [ANG_W+1:0] atan_q16(input int i);
      case (i)
         0:       atan_q16 = 28'sd2949120;
         1:       atan_q16 = 28'sd1740967;
         2:       atan_q16 = 28'sd919879;
         3:       atan_q16 = 28'sd466945;
         4:       atan_q16 = 28'sd234379;
         5:       atan_q16 = 28'sd117304;
         6:       atan_q16 = 28'sd58666;
         7:       atan_q16 = 28'sd29335;
         8:       atan_q16 = 28'sd14668;
         9:       atan_q16 = 28'sd7334;
         10:      atan_q16 = 28'sd3667;
         11:      atan_q16 = 28'sd1833;
         12:      atan_q16 = 28'sd917;
         13:      atan_q16 = 28'sd458;
         14:      atan_q16 = 28'sd229;
         15:      atan_q16 = 28'sd115;
         default: atan_q16 = '0;
      endcase
   endfunction

endpackage

// ===== src/cmdt_rot_cell.sv =====
// ----------------------------------------------------------------------------
// cordic rotation cell
// one micro-rotation for a cosine/sine pair, registered, held while stalled
// ----------------------------------------------------------------------------
module cmdt_rot_cell #(
   parameter int STEP = 0
) (
   input  logic                clock,
   input  logic                enable,
   input  cmdt_pkg::rot_type   rot_in,
   output cmdt_pkg::rot_type   rot_out
);

   cmdt_pkg::rot_type rot_ff, rot_in_d;
   logic signed [cmdt_pkg::VEC_W-1:0] dx, dy;

   always_comb begin
      dx = rot_in.y >>> STEP;
      dy = rot_in.x >>> STEP;
      rot_in_d = rot_in;
      if (!rot_in.z[cmdt_pkg::ANG_W+1]) begin
         rot_in_d.x = rot_in.x - dx;
         rot_in_d.y = rot_in.y + dy;
         rot_in_d.z = rot_in.z - cmdt_pkg::atan_q16(STEP);
      end else begin
         rot_in_d.x = rot_in.x + dx;
         rot_in_d.y = rot_in.y - dy;
         rot_in_d.z = rot_in.z + cmdt_pkg::atan_q16(STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         rot_ff <= rot_in_d;
      end
   end

   assign rot_out = rot_ff;

endmodule

// ===== src/cmdt_div_cell.sv =====
// ----------------------------------------------------------------------------
// restoring divider cell
// produces one quotient bit per stage for both texel indices
// ----------------------------------------------------------------------------
module cmdt_div_cell #(
   parameter int BIT = 0
) (
   input  logic                          clock,
   input  logic [cmdt_pkg::DIV_W-1:0]    rem_c_in,
   input  logic [cmdt_pkg::DIV_W-1:0]    rem_r_in,
   input  logic [cmdt_pkg::SIZE_W-1:0]   q_c_in,
   input  logic [cmdt_pkg::SIZE_W-1:0]   q_r_in,
   input  logic [cmdt_pkg::VEC_W:0]      den_in,
   input  logic [cmdt_pkg::FACE_W-1:0]   face_in,
   output logic [cmdt_pkg::DIV_W-1:0]    rem_c_out,
   output logic [cmdt_pkg::DIV_W-1:0]    rem_r_out,
   output logic [cmdt_pkg::SIZE_W-1:0]   q_c_out,
   output logic [cmdt_pkg::SIZE_W-1:0]   q_r_out,
   output logic [cmdt_pkg::VEC_W:0]      den_out,
   output logic [cmdt_pkg::FACE_W-1:0]   face_out
);
   localparam int DW = cmdt_pkg::DIV_W;

   logic [DW-1:0] rc_ff, rr_ff, rc_in, rr_in, shd;
   logic [cmdt_pkg::SIZE_W-1:0] qc_ff, qr_ff, qc_in, qr_in;
   logic [cmdt_pkg::VEC_W:0] den_ff;
   logic [cmdt_pkg::FACE_W-1:0] face_ff;

   // divisor shifted to this bit; no overflow since quotient fits SIZE_W
   assign shd = DW'(den_in) << BIT;

   always_comb begin
      rc_in = rem_c_in;
      rr_in = rem_r_in;
      qc_in = q_c_in;
      qr_in = q_r_in;
      if ((rem_c_in >> BIT) >= DW'(den_in)) begin
         rc_in = rem_c_in - shd;
         qc_in[BIT] = 1'b1;
      end
      if ((rem_r_in >> BIT) >= DW'(den_in)) begin
         rr_in = rem_r_in - shd;
         qr_in[BIT] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rc_ff   <= rc_in;
      rr_ff   <= rr_in;
      qc_ff   <= qc_in;
      qr_ff   <= qr_in;
      den_ff  <= den_in;
      face_ff <= face_in;
   end

   assign rem_c_out = rc_ff;
   assign rem_r_out = rr_ff;
   assign q_c_out   = qc_ff;
   assign q_r_out   = qr_ff;
   assign den_out   = den_ff;
   assign face_out  = face_ff;

endmodule

// ===== src/cube_map_direction_to_texel.sv =====
// pipeline: 37 register stages (capture, 2 reduction, 16 cordic, 4 mid, 13 divider, output)
// throughput: one word per cycle; every stage moves only when the output can drain
// the whole datapath is a row of cells that stall together on rsp_tready
// reset clears the valid chain only; data registers are not reset
// ----------------------------------------------------------------------------
// cube map direction to texel
// latitude/longitude to cube face, column and row
// ----------------------------------------------------------------------------
module cube_map_direction_to_texel #(
   parameter int FACE_WIDTH  = cmdt_pkg::FACE_WIDTH_DEF,
   parameter int FACE_HEIGHT = cmdt_pkg::FACE_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [55:0] req_tdata,   // latitude_deg[25:0], longitude_deg[51:26]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata    // face[2:0], column[13:3], row[24:14]
);
   localparam int AW = cmdt_pkg::ANG_W;
   localparam int VW = cmdt_pkg::VEC_W;
   localparam int NS = cmdt_pkg::CORDIC_STEPS;
   localparam int SW = cmdt_pkg::SIZE_W;
   localparam int DW = cmdt_pkg::DIV_W;
   localparam int QB = SW;              // quotient bits
   localparam int PRE = 3;
   localparam int MID = 4;
   localparam int LAT = PRE + NS + MID + QB;

   // global stall: the whole row advances when the output slot frees
   logic adv;
   logic [LAT:0] vld_ff;
   assign adv = !vld_ff[LAT] || rsp_tready;
   assign req_tready = adv;

   logic [LAT:0] vld_in;
   always_comb begin
      vld_in = {vld_ff[LAT-1:0], req_tvalid};
   end
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // ---- stage 0: capture, stages 1/2: angle reduction
   logic signed [AW-1:0] ang_ff [2];
   logic signed [AW-1:0] rem_ff [2], rem_in [2];
   logic signed [AW+1:0] red_ff [2], red_in [2];
   logic                 flp_ff [2], flp_in [2];

   // input spans less than two turns, so one compare and subtract does the remainder
   always_comb begin
      for (int k = 0; k < 2; k++) begin
         if (ang_ff[k] >= cmdt_pkg::TURN_Q16) begin
            rem_in[k] = ang_ff[k] - cmdt_pkg::TURN_Q16;
         end else if (ang_ff[k] <= -cmdt_pkg::TURN_Q16) begin
            rem_in[k] = ang_ff[k] + cmdt_pkg::TURN_Q16;
         end else begin
            rem_in[k] = ang_ff[k];
         end
      end
   end

   always_comb begin
      logic signed [AW+1:0] r;
      for (int k = 0; k < 2; k++) begin
         r = (AW+2)'(rem_ff[k]);
         if (r >= cmdt_pkg::HALF_TURN_Q16) r = r - (AW+2)'(cmdt_pkg::TURN_Q16);
         if (r < -cmdt_pkg::HALF_TURN_Q16) r = r + (AW+2)'(cmdt_pkg::TURN_Q16);
         flp_in[k] = 1'b0;
         if (r > cmdt_pkg::QUARTER_TURN_Q16) begin
            r = r - cmdt_pkg::HALF_TURN_Q16;
            flp_in[k] = 1'b1;
         end else if (r < -cmdt_pkg::QUARTER_TURN_Q16) begin
            r = r + cmdt_pkg::HALF_TURN_Q16;
            flp_in[k] = 1'b1;
         end
         red_in[k] = r;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ang_ff[0] <= req_tdata[AW-1:0];
         ang_ff[1] <= req_tdata[2*AW-1:AW];
         rem_ff    <= rem_in;
         red_ff    <= red_in;
         flp_ff    <= flp_in;
      end
   end

   // ---- cordic cells, two lanes
   cmdt_pkg::rot_type rot [2][NS+1];

   for (genvar k = 0; k < 2; k++) begin : g_lane
      assign rot[k][0] = '{x: cmdt_pkg::CORDIC_GAIN_Q16, y: '0,
                           z: red_ff[k], flip: flp_ff[k]};
      for (genvar s = 0; s < NS; s++) begin : g_cell
         cmdt_rot_cell #(.STEP(s)) u_cell (
            .clock  (clock),
            .enable (adv),
            .rot_in (rot[k][s]),
            .rot_out(rot[k][s+1])
         );
      end
   end

   // ---- mid stages: cos/sin, vector, scores, projection
   logic signed [VW-1:0] cl_ff, sl_ff, cg_ff, sg_ff;
   logic signed [VW-1:0] vx_ff, vy_ff, vz_ff;
   logic [cmdt_pkg::FACE_W-1:0] face_ff, face_in, face2_ff;
   logic signed [VW-1:0] best_ff, best_in, left_ff, up_ff;
   logic [DW-1:0] numc_ff, numr_ff, numc_in, numr_in;
   logic [VW:0]   den_ff;
   logic signed [2*VW-1:0] pxx, pzz;

   assign pxx = cl_ff * cg_ff;
   assign pzz = cl_ff * sg_ff;

   always_comb begin
      logic signed [VW-1:0] sc [6];
      sc[0] = vz_ff; sc[1] = -vz_ff; sc[2] = -vx_ff;
      sc[3] = vx_ff; sc[4] = -vy_ff; sc[5] = vy_ff;
      best_in = sc[0];
      face_in = cmdt_pkg::FACE_POS_Z;
      for (int k = 1; k < 6; k++) begin
         if (sc[k] > best_in) begin
            best_in = sc[k];
            face_in = cmdt_pkg::FACE_W'(k);
         end
      end
      if (best_in < VW'(1)) best_in = VW'(1);
   end

   always_comb begin
      logic signed [DW:0] nc, nr;
      nc = (DW+1)'(left_ff + best_ff) * (DW+1)'(FACE_WIDTH);
      nr = (DW+1)'(up_ff + best_ff) * (DW+1)'(FACE_HEIGHT);
      numc_in = nc[DW] ? '0 : nc[DW-1:0];
      numr_in = nr[DW] ? '0 : nr[DW-1:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         cl_ff <= rot[0][NS].flip ? -rot[0][NS].x : rot[0][NS].x;
         sl_ff <= rot[0][NS].flip ? -rot[0][NS].y : rot[0][NS].y;
         cg_ff <= rot[1][NS].flip ? -rot[1][NS].x : rot[1][NS].x;
         sg_ff <= rot[1][NS].flip ? -rot[1][NS].y : rot[1][NS].y;
         vx_ff <= VW'(pxx >>> 16);
         vz_ff <= VW'(pzz >>> 16);
         vy_ff <= sl_ff;
         face_ff <= face_in;
         best_ff <= best_in;
         left_ff <= (face_in < cmdt_pkg::FACE_NEG_Y) ? vy_ff : vx_ff;
         up_ff   <= (face_in < cmdt_pkg::FACE_NEG_X) ? vx_ff : vz_ff;
         numc_ff <= numc_in;
         numr_ff <= numr_in;
         den_ff  <= {best_ff, 1'b0};
         face2_ff <= face_ff;
      end
   end

   // ---- divider cells, msb first
   logic [DW-1:0] drc [QB+1], drr [QB+1];
   logic [SW-1:0] dqc [QB+1], dqr [QB+1];
   logic [VW:0]   dden [QB+1];
   logic [cmdt_pkg::FACE_W-1:0] dface [QB+1];

   assign drc[0] = numc_ff;
   assign drr[0] = numr_ff;
   assign dqc[0] = '0;
   assign dqr[0] = '0;
   assign dden[0] = den_ff;
   assign dface[0] = face2_ff;

   for (genvar b = 0; b < QB; b++) begin : g_div
      logic [DW-1:0] rci, rri;
      logic [SW-1:0] qci, qri;
      logic [VW:0]   dni;
      logic [cmdt_pkg::FACE_W-1:0] fci;
      logic [DW-1:0] rco, rro;
      logic [SW-1:0] qco, qro;
      logic [VW:0]   dno;
      logic [cmdt_pkg::FACE_W-1:0] fco;
      // on stall re-enter a held copy of the cell input, whose quotient bit is still clear
      logic [DW-1:0] hrc_ff, hrr_ff;
      logic [SW-1:0] hqc_ff, hqr_ff;
      logic [VW:0]   hdn_ff;
      logic [cmdt_pkg::FACE_W-1:0] hfc_ff;
      always_ff @(posedge clock) begin
         if (adv) begin
            hrc_ff <= drc[b]; hrr_ff <= drr[b];
            hqc_ff <= dqc[b]; hqr_ff <= dqr[b];
            hdn_ff <= dden[b]; hfc_ff <= dface[b];
         end
      end
      assign rci = adv ? drc[b] : hrc_ff;
      assign rri = adv ? drr[b] : hrr_ff;
      assign qci = adv ? dqc[b] : hqc_ff;
      assign qri = adv ? dqr[b] : hqr_ff;
      assign dni = adv ? dden[b] : hdn_ff;
      assign fci = adv ? dface[b] : hfc_ff;
      cmdt_div_cell #(.BIT(QB-1-b)) u_cell (
         .clock(clock),
         .rem_c_in(rci), .rem_r_in(rri), .q_c_in(qci), .q_r_in(qri),
         .den_in(dni), .face_in(fci),
         .rem_c_out(rco), .rem_r_out(rro), .q_c_out(qco), .q_r_out(qro),
         .den_out(dno), .face_out(fco)
      );
      assign drc[b+1] = rco; assign drr[b+1] = rro;
      assign dqc[b+1] = qco; assign dqr[b+1] = qro;
      assign dden[b+1] = dno; assign dface[b+1] = fco;
   end

   // ---- output register with clamp
   logic [cmdt_pkg::FACE_W-1:0] oface_ff;
   logic [cmdt_pkg::IDX_W-1:0]  ocol_ff, orow_ff;
   logic [SW-1:0] cc, cr;

   always_comb begin
      cc = (dqc[QB] > SW'(FACE_WIDTH - 1))  ? SW'(FACE_WIDTH - 1)  : dqc[QB];
      cr = (dqr[QB] > SW'(FACE_HEIGHT - 1)) ? SW'(FACE_HEIGHT - 1) : dqr[QB];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         oface_ff <= dface[QB];
         ocol_ff  <= cc[cmdt_pkg::IDX_W-1:0];
         orow_ff  <= cr[cmdt_pkg::IDX_W-1:0];
      end
   end

   assign rsp_tvalid = vld_ff[LAT];
   assign rsp_tdata  = {7'd0, orow_ff, ocol_ff, oface_ff};

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cube map direction to texel testbench
// drives latitude/longitude words with bursty gaps and random output stalls,
// predicts face, column and row with a bit-exact cordic model and checks in order
// ----------------------------------------------------------------------------
module testbench;

   localparam int N_RANDOM    = 880;
   localparam int IDLE_LIMIT  = 20000;
   localparam int DRAIN_EXTRA = 60;
   localparam longint TURN    = 23592960;
   localparam longint HALF    = 11796480;
   localparam longint QUARTER = 5898240;
   localparam longint ANG_MAX = 23592960;

   typedef struct {
      longint lat;
      longint lng;
   } dir_type;

   typedef struct {
      cmdt_pkg::face_type face;
      logic [10:0] column;
      logic [10:0] row;
   } texel_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [55:0] req_tdata;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;

   texel_type texel_queue[$];
   dir_type   dir_list[$];
   int     errors;
   int     idle_cycles;
   bit     all_sent;

   cube_map_direction_to_texel u_top (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic longint floor_shift(longint v, int s);
      return v >>> s;
   endfunction

   function automatic void angle_cos_sin(longint deg, output longint c, output longint s);
      longint r;
      longint x;
      longint y;
      longint dx;
      longint dy;
      bit     flip;
      r = deg % TURN;
      x = 39797;
      y = 0;
      flip = 0;
      if (r >= HALF) r -= TURN;
      if (r < -HALF) r += TURN;
      if (r > QUARTER) begin
         r -= HALF;
         flip = 1;
      end else if (r < -QUARTER) begin
         r += HALF;
         flip = 1;
      end
      for (int i = 0; i < 16; i++) begin
         dx = floor_shift(y, i);
         dy = floor_shift(x, i);
         if (r >= 0) begin
            x -= dx; y += dy; r -= longint'(cmdt_pkg::atan_q16(i));
         end else begin
            x += dx; y -= dy; r += longint'(cmdt_pkg::atan_q16(i));
         end
      end
      c = flip ? -x : x;
      s = flip ? -y : y;
   endfunction

   function automatic logic [10:0] texel_coord(longint p, longint b, longint size);
      longint num;
      longint q;
      num = (p + b) * size;
      if (num < 0) return '0;
      q = num / (2 * b);
      if (q > size - 1) q = size - 1;
      return q[10:0];
   endfunction

   function automatic texel_type predict_texel(longint lat, longint lng);
      longint cl, sl, cg, sg, vx, vy, vz, best, left, up;
      longint score[6];
      int     f;
      texel_type t;
      angle_cos_sin(lat, cl, sl);
      angle_cos_sin(lng, cg, sg);
      vx = floor_shift(cl * cg, 16);
      vy = sl;
      vz = floor_shift(cl * sg, 16);
      score[0] = vz;  score[1] = -vz;
      score[2] = -vx; score[3] = vx;
      score[4] = -vy; score[5] = vy;
      best = score[0];
      f = 0;
      for (int k = 1; k < 6; k++) begin
         if (score[k] > best) begin
            best = score[k];
            f = k;
         end
      end
      if (best < 1) best = 1;
      left = (f < 4) ? vy : vx;
      up   = (f < 2) ? vx : vz;
      t.face   = cmdt_pkg::face_type'(f);
      t.column = texel_coord(left, best, 2048);
      t.row    = texel_coord(up, best, 2048);
      return t;
   endfunction

   function automatic longint random_angle();
      int sel;
      sel = $urandom_range(0, 9);
      if (sel == 0) return longint'($urandom_range(0, 8)) * 45 * 65536 - 4 * 45 * 65536;
      if (sel == 1) return longint'($signed(26'($urandom)));
      if (sel < 5) return longint'($urandom_range(0, 2 * 5898240)) - 5898240;
      return longint'($urandom_range(0, 2 * ANG_MAX)) - ANG_MAX;
   endfunction

   // directed table: poles, axes, wraps, field extremes, face ties
   initial begin
      dir_type d;
      longint deg_table[][2] = '{
         '{0, 0}, '{5898240, 0}, '{-5898240, 0}, '{0, 5898240}, '{0, -5898240},
         '{0, 11796480}, '{0, -11796480}, '{23592960, 23592960},
         '{-23592960, -23592960}, '{33554431, -33554432}, '{-33554432, 33554431},
         '{0, 2949120}, '{0, -2949120}, '{2949120, 0}, '{-2949120, 11796480},
         '{7864320, 0}, '{-7864320, 5898240}, '{11796480, 0}, '{17694720, 1},
         '{-1, -1}, '{1, 1}, '{2321089, 2949120}, '{-2321089, -8847360},
         '{5898239, 0}, '{0, 23592959}
      };
      foreach (deg_table[i]) begin
         d.lat = deg_table[i][0];
         d.lng = deg_table[i][1];
         dir_list.push_back(d);
      end
      for (int i = 0; i < N_RANDOM; i++) begin
         d.lat = random_angle();
         d.lng = random_angle();
         dir_list.push_back(d);
      end
   end

   // sender: bursts with random gaps
   initial begin
      int burst;
      int gap;
      dir_type d;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      all_sent   = 1'b0;
      reset      = 1'b1;
      clock      = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      while (dir_list.size() > 0) begin
         burst = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         for (int b = 0; b < burst && dir_list.size() > 0; b++) begin
            d = dir_list.pop_front();
            req_tvalid <= 1'b1;
            req_tdata  <= {4'b0, 26'(d.lng), 26'(d.lat)};
            @(posedge clock);
            while (!req_tready) @(posedge clock);
            texel_queue.push_back(predict_texel(d.lat, d.lng));
         end
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
      all_sent = 1'b1;
   end

   // receiver: stall pattern cycles through calm and busy phases
   initial begin
      int cyc;
      rsp_tready = 1'b0;
      cyc = 0;
      forever begin
         @(posedge clock);
         cyc++;
         case ((cyc / 300) % 3)
            0: rsp_tready <= 1'b1;
            1: rsp_tready <= ($urandom_range(0, 3) != 0);
            default: rsp_tready <= (cyc % 7 < 3);
         endcase
      end
   end

   // result check
   always @(posedge clock) begin
      texel_type want;
      logic [2:0]  got_face;
      logic [10:0] got_col;
      logic [10:0] got_row;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_face = rsp_tdata[2:0];
         got_col  = rsp_tdata[13:3];
         got_row  = rsp_tdata[24:14];
         if (texel_queue.size() == 0) begin
            $display("%0t: unexpected word face=%0d column=%0d row=%0d",
                     $time, got_face, got_col, got_row);
            errors++;
         end else begin
            want = texel_queue.pop_front();
            if (got_face !== want.face || got_col !== want.column || got_row !== want.row) begin
               $display("%0t: mismatch expected face=%0d column=%0d row=%0d, got %0d %0d %0d",
                        $time, want.face, want.column, want.row, got_face, got_col, got_row);
               errors++;
            end
         end
      end
   end

   // watchdog and end of run
   initial begin
      errors = 0;
      idle_cycles = 0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
         end
         if (all_sent && texel_queue.size() == 0) begin
            repeat (DRAIN_EXTRA) @(posedge clock);
            if (errors == 0) begin
               $display("*** PASSED ***");
            end else begin
               $display("*** FAILED ***");
            end
            $finish;
         end
      end
   end

endmodule

// ===== filelist.f =====
src/cmdt_pkg.sv
src/cmdt_rot_cell.sv
src/cmdt_div_cell.sv
src/cube_map_direction_to_texel.sv
tb/testbench.sv
